// ----- hdl/cdo_pkg.sv -----
// -----------------------------------------------------------------------------
// cdo_pkg
// Shared types, constants and calendar helpers for the date offset block.
// -----------------------------------------------------------------------------
package cdo_pkg;

  localparam int OFFSET_BITS = 22;

  localparam int YEAR_IN_W  = 15;
  localparam int YEAR_OUT_W = 16;
  localparam int YEAR_W     = YEAR_OUT_W + 1;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int STATUS_W   = 2;
  localparam int R400_W     = 9;
  localparam int QUOT_W     = 7;

  localparam int IN_BITS      = YEAR_IN_W + MONTH_W + DAY_W + OFFSET_BITS;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = YEAR_OUT_W + MONTH_W + DAY_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  localparam logic [YEAR_IN_W-1:0] YEAR_MIN = 15'd1601;
  localparam logic [YEAR_IN_W-1:0] YEAR_MAX = 15'd30826;

  // floor(y / 400) == (y * RECIP_400) >> RECIP_SHIFT for every 15-bit y
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 21;
  localparam int PROD_W      = YEAR_IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_400 = 13'd5243;

  localparam logic [R400_W-1:0] CYCLE_LEN  = 9'd400;
  localparam logic [R400_W-1:0] CYCLE_LAST = 9'd399;

  localparam logic [MONTH_W-1:0] M_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] M_DEC = 4'd12;

  typedef struct packed {
    logic load;
    logic div;
    logic rem;
    logic chk;
    logic step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_end;
  } dp_sts_t;

  // Leap test from year mod 400: mod 4 is zero, mod 100 is not, or mod 400 is.
  function automatic logic is_leap(input logic [R400_W-1:0] r400);
    logic hundred;
    hundred = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
    return (r400[1:0] == 2'b00) && !hundred;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      M_FEB:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- hdl/cdo_ctrl.sv -----
// -----------------------------------------------------------------------------
// cdo_ctrl
// Sequencer: load, year mod 400, date check, month walk, result hand-off.
// -----------------------------------------------------------------------------
module cdo_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  cdo_pkg::dp_sts_t sts_i,
  output cdo_pkg::dp_cmd_t cmd_o
);
  import cdo_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_REM  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       s_accept;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = S_REM;
      end
      S_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = S_WALK;
      end
      S_WALK: begin
        if (sts_i.walk_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == S_DIV))
    else $error("accepted request did not start the sequence");

  a_walk_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && sts_i.walk_end) |=> (state_q == S_DONE))
    else $error("walk end did not reach result stage");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten while pending");

endmodule

// ----- hdl/cdo_dp.sv -----
// -----------------------------------------------------------------------------
// cdo_dp
// Datapath: input capture, year mod 400, date check, one month per step.
// -----------------------------------------------------------------------------
module cdo_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cdo_pkg::dp_cmd_t                 cmd_i,
  output cdo_pkg::dp_sts_t                 sts_o,
  input  logic [cdo_pkg::YEAR_IN_W-1:0]    year_in_i,
  input  logic [cdo_pkg::MONTH_W-1:0]      month_in_i,
  input  logic [cdo_pkg::DAY_W-1:0]        day_in_i,
  input  logic signed [cdo_pkg::OFFSET_BITS-1:0] day_offset_i,
  output logic [cdo_pkg::YEAR_OUT_W-1:0]   year_out_o,
  output logic [cdo_pkg::MONTH_W-1:0]      month_out_o,
  output logic [cdo_pkg::DAY_W-1:0]        day_out_o,
  output logic [cdo_pkg::STATUS_W-1:0]     status_o
);
  import cdo_pkg::*;

  logic [YEAR_IN_W-1:0]   yi_q;
  logic [MONTH_W-1:0]     mi_q;
  logic [DAY_W-1:0]       di_q;
  logic [YEAR_W-1:0]      y_q, y_d;
  logic [MONTH_W-1:0]     m_q, m_d;
  logic [DAY_W-1:0]       d_q, d_d;
  logic [OFFSET_BITS-1:0] x_q, x_d;
  logic                   neg_q;
  logic [R400_W-1:0]      r400_q, r400_d;
  logic [QUOT_W-1:0]      quot_q;
  logic [STATUS_W-1:0]    st_q, st_d;

  logic [PROD_W-1:0]      prod;
  logic [YEAR_OUT_W-1:0]  rem_raw;
  logic [YEAR_OUT_W-1:0]  rem_fix;
  logic                   in_valid;
  logic [DAY_W-1:0]       cur_len;
  logic [DAY_W-1:0]       fwd_room;
  logic                   wrap;

  assign prod    = PROD_W'(yi_q) * PROD_W'(RECIP_400);
  assign rem_raw = YEAR_OUT_W'(yi_q) - (YEAR_OUT_W'(quot_q) * YEAR_OUT_W'(CYCLE_LEN));
  assign rem_fix = (rem_raw >= YEAR_OUT_W'(CYCLE_LEN)) ?
                   (rem_raw - YEAR_OUT_W'(CYCLE_LEN)) : rem_raw;

  assign in_valid = (yi_q >= YEAR_MIN) && (yi_q <= YEAR_MAX) &&
                    (mi_q >= M_JAN) && (mi_q <= M_DEC) && (di_q != '0) &&
                    (di_q <= month_len(mi_q, is_leap(r400_q)));

  assign cur_len  = month_len(m_q, is_leap(r400_q));
  assign fwd_room = cur_len - d_q;

  assign sts_o.walk_end = (x_q == '0) || (st_q != ST_OK);

  always_comb begin
    y_d    = y_q;
    m_d    = m_q;
    d_d    = d_q;
    x_d    = x_q;
    r400_d = r400_q;
    st_d   = st_q;
    wrap   = 1'b0;
    if (!neg_q) begin
      if (OFFSET_BITS'(fwd_room) < x_q) begin
        d_d = DAY_W'(1);
        x_d = x_q - OFFSET_BITS'(fwd_room) - OFFSET_BITS'(1);
        if (m_q == M_DEC) begin
          wrap   = 1'b1;
          m_d    = M_JAN;
          y_d    = y_q + YEAR_W'(1);
          r400_d = (r400_q == CYCLE_LAST) ? '0 : r400_q + R400_W'(1);
        end else begin
          m_d = m_q + MONTH_W'(1);
        end
        if (wrap && y_d[YEAR_W-1]) begin
          st_d = ST_RANGE;
        end
      end else begin
        d_d = d_q + x_q[DAY_W-1:0];
        x_d = '0;
      end
    end else begin
      if (OFFSET_BITS'(d_q) <= x_q) begin
        x_d = x_q - OFFSET_BITS'(d_q);
        if (m_q == M_JAN) begin
          wrap   = 1'b1;
          m_d    = M_DEC;
          y_d    = y_q - YEAR_W'(1);
          r400_d = (r400_q == '0) ? CYCLE_LAST : r400_q - R400_W'(1);
        end else begin
          m_d = m_q - MONTH_W'(1);
        end
        if (wrap && (y_d == '0)) begin
          st_d = ST_RANGE;
        end
        d_d = month_len(m_d, is_leap(r400_d));
      end else begin
        d_d = d_q - x_q[DAY_W-1:0];
        x_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      yi_q  <= year_in_i;
      mi_q  <= month_in_i;
      di_q  <= day_in_i;
      y_q   <= YEAR_W'(year_in_i);
      m_q   <= month_in_i;
      d_q   <= day_in_i;
      neg_q <= day_offset_i[OFFSET_BITS-1];
      x_q   <= day_offset_i[OFFSET_BITS-1] ? (OFFSET_BITS'(0) - day_offset_i)
                                           : day_offset_i;
      st_q  <= ST_OK;
    end
    if (cmd_i.div) begin
      quot_q <= prod[RECIP_SHIFT +: QUOT_W];
    end
    if (cmd_i.rem) begin
      r400_q <= rem_fix[R400_W-1:0];
    end
    if (cmd_i.chk && !in_valid) begin
      st_q <= ST_INVALID;
    end
    if (cmd_i.step) begin
      y_q    <= y_d;
      m_q    <= m_d;
      d_q    <= d_d;
      x_q    <= x_d;
      r400_q <= r400_d;
      st_q   <= st_d;
    end
    if (cmd_i.out_load) begin
      status_o <= st_q;
      if (st_q == ST_OK) begin
        year_out_o  <= y_q[YEAR_OUT_W-1:0];
        month_out_o <= m_q;
        day_out_o   <= d_q;
      end else begin
        year_out_o  <= YEAR_OUT_W'(yi_q);
        month_out_o <= mi_q;
        day_out_o   <= di_q;
      end
    end
  end

  a_r400_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (r400_q < CYCLE_LEN))
    else $error("year mod 400 out of range during walk");

  a_day_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && st_d == ST_OK) |=> (d_q != '0))
    else $error("walk produced day zero");

  a_step_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> ((x_q < $past(x_q)) || (st_q == ST_RANGE)))
    else $error("walk step made no progress");

endmodule

// ----- hdl/calendar_date_day_offset.sv -----
// -----------------------------------------------------------------------------
// calendar_date_day_offset
// Gregorian date plus signed day offset, walked one month per cycle.
// -----------------------------------------------------------------------------
//  channel  | dir | contents
//  s_axis   | in  | year_in, month_in, day_in, day_offset (tdata)
//  m_axis   | out | year_out, month_out, day_out (tdata), status (tuser)
//
//  A request passes from accept through the DIV, REM, CHK and WALK states to
//  DONE, then to result valid; WALK takes one step per month boundary crossed,
//  plus one for a final partial month when the walk does not end exactly on a
//  boundary. Invalid input dates and a zero offset take no walk steps; a result
//  year out of range stops the walk at the step that leaves the year range.
//  Reset is asynchronous, active low; it clears the sequencer and result valid.
//  The result register lets the next request enter while a result is pending.
// -----------------------------------------------------------------------------
module calendar_date_day_offset (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // year_in[14:0], month_in[18:15], day_in[23:19], day_offset[45:24]
  input  logic [cdo_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // year_out[15:0], month_out[19:16], day_out[24:20]
  output logic [cdo_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // status[1:0]
  output logic [cdo_pkg::STATUS_W-1:0]       m_axis_tuser
);
  import cdo_pkg::*;

  localparam int MON_LSB = YEAR_IN_W;
  localparam int DAY_LSB = MON_LSB + MONTH_W;
  localparam int OFF_LSB = DAY_LSB + DAY_W;

  dp_cmd_t                 cmd;
  dp_sts_t                 sts;
  logic [YEAR_OUT_W-1:0]   year_out;
  logic [MONTH_W-1:0]      month_out;
  logic [DAY_W-1:0]        day_out;

  cdo_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  cdo_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .year_in_i    (s_axis_tdata[YEAR_IN_W-1:0]),
    .month_in_i   (s_axis_tdata[MON_LSB +: MONTH_W]),
    .day_in_i     (s_axis_tdata[DAY_LSB +: DAY_W]),
    .day_offset_i (s_axis_tdata[OFF_LSB +: OFFSET_BITS]),
    .year_out_o   (year_out),
    .month_out_o  (month_out),
    .day_out_o    (day_out),
    .status_o     (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TDATA_W'({day_out, month_out, year_out});

endmodule
